/* rtl/ps2mt_pkg.sv */
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, codes and sizes for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mt_pkg;

  // cursor positions are also limited to 2^POS_BITS - 1
  localparam int POS_BITS = 16;
  localparam logic [16:0] POS_MAX = 17'((64'd1 << POS_BITS) - 64'd1);

  // command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // request opcodes
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_READ   = 2'd1,
    OP_CENTER = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_WHEEL_MODE    = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  localparam logic [15:0] WIDTH_RESET  = 16'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;

  // packet header bits
  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XSGN_BIT = 4;
  localparam int HDR_YSGN_BIT = 5;
  localparam logic [7:0] HDR_OVF_MASK = 8'hC0;

  // what the back end does with one request
  typedef enum logic [2:0] {
    CMD_SHOW   = 3'd0,
    CMD_APPLY  = 3'd1,
    CMD_DROP   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CENTER = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         buttons;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic signed [3:0]  dz;
    logic               use_wheel;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/ps2mt_if.sv */
// ----------------------------------------------------------------------------
// ps2mt_if
// Valid/ready channels of the tracker: request channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2mt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ps2mt_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic [2:0]         button_bits;
  logic signed [15:0] scroll_sum;
  logic               update_pending;
  logic               packet_done;
  logic               packet_dropped;

  modport source (output valid, output pos_x, output pos_y, output button_bits,
                  output scroll_sum, output update_pending, output packet_done,
                  output packet_dropped, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input button_bits,
                  input scroll_sum, input update_pending, input packet_done,
                  input packet_dropped, output ready);
endinterface

`default_nettype wire

/* rtl/ps2mt_front.sv */
// ----------------------------------------------------------------------------
// ps2mt_front
// Accepts requests, frames mouse bytes into packets and emits commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  ps2mt_in_if.sink             in_if,
  input  wire logic            wheel_mode,
  input  wire logic            q_full,
  output      logic            q_push,
  output      ps2mt_pkg::cmd_t q_data
);

  logic [1:0] byte_index_r, byte_index_nxt;
  logic [7:0] pkt_r [3];
  logic [1:0] last_idx;
  logic [7:0] hdr;
  logic [7:0] ybyte;
  logic       accept;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign q_push      = accept;
  assign last_idx    = wheel_mode ? 2'd3 : 2'd2;
  assign hdr         = pkt_r[0];
  // third byte may be the one arriving now
  assign ybyte       = (byte_index_r == 2'd2) ? in_if.rx_byte : pkt_r[2];

  always_comb begin
    byte_index_nxt    = byte_index_r;
    q_data.kind       = ps2mt_pkg::CMD_SHOW;
    q_data.buttons    = hdr[2:0];
    q_data.dx         = $signed({hdr[ps2mt_pkg::HDR_XSGN_BIT], pkt_r[1]});
    q_data.dy         = $signed({hdr[ps2mt_pkg::HDR_YSGN_BIT], ybyte});
    q_data.dz         = $signed(in_if.rx_byte[3:0]);
    q_data.use_wheel  = wheel_mode;
    case (ps2mt_pkg::opcode_t'(in_if.opcode))
      ps2mt_pkg::OP_BYTE: begin
        if (byte_index_r == 2'd0 && !in_if.rx_byte[ps2mt_pkg::HDR_SYNC_BIT]) begin
          q_data.kind = ps2mt_pkg::CMD_SHOW;   // out of sync, drop
        end else if (byte_index_r < last_idx && byte_index_r != 2'd3) begin
          byte_index_nxt = byte_index_r + 2'd1;
          q_data.kind    = ps2mt_pkg::CMD_SHOW;
        end else begin
          byte_index_nxt = 2'd0;
          if ((hdr & ps2mt_pkg::HDR_OVF_MASK) != 8'h00) begin
            q_data.kind = ps2mt_pkg::CMD_DROP;
          end else begin
            q_data.kind = ps2mt_pkg::CMD_APPLY;
          end
        end
      end
      ps2mt_pkg::OP_READ:   q_data.kind = ps2mt_pkg::CMD_READ;
      ps2mt_pkg::OP_CENTER: q_data.kind = ps2mt_pkg::CMD_CENTER;
      default:              q_data.kind = ps2mt_pkg::CMD_SHOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= 2'd0;
    end else if (accept) begin
      byte_index_r <= byte_index_nxt;
    end
  end

  // packet byte store: no reset, always written before use
  always_ff @(posedge clk) begin
    if (accept && ps2mt_pkg::opcode_t'(in_if.opcode) == ps2mt_pkg::OP_BYTE &&
        byte_index_r != 2'd3 &&
        !(byte_index_r == 2'd0 && !in_if.rx_byte[ps2mt_pkg::HDR_SYNC_BIT])) begin
      pkt_r[byte_index_r] <= in_if.rx_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/ps2mt_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// ps2mt_cmd_fifo
// Short command queue decoupling the framing front from the state back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ps2mt_pkg::cmd_t push_data,
  output      logic            full,
  input  wire logic            pop,
  output      ps2mt_pkg::cmd_t pop_data,
  output      logic            empty
);

  ps2mt_pkg::cmd_t                mem_r [ps2mt_pkg::QDEPTH];
  logic [ps2mt_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ps2mt_pkg::QCNT_W-1:0]   count_r;
  logic                           do_push, do_pop;

  localparam logic [ps2mt_pkg::QPTR_W-1:0] PTR_LAST =
    ps2mt_pkg::QPTR_W'(ps2mt_pkg::QDEPTH - 1);
  localparam logic [ps2mt_pkg::QCNT_W-1:0] CNT_FULL =
    ps2mt_pkg::QCNT_W'(ps2mt_pkg::QDEPTH);

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/ps2mt_back.sv */
// ----------------------------------------------------------------------------
// ps2mt_back
// Executes commands on cursor, buttons, scroll and pending; registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     screen_width,
  input  wire logic [15:0]     screen_height,
  input  wire logic            q_empty,
  input  wire ps2mt_pkg::cmd_t q_data,
  output      logic            q_pop,
  ps2mt_out_if.source          out_if
);

  logic [15:0] cur_x_r, cur_x_nxt;
  logic [15:0] cur_y_r, cur_y_nxt;
  logic [2:0]  btn_r, btn_nxt;
  logic [15:0] scroll_r, scroll_nxt;
  logic        pend_r, pend_nxt;

  logic               out_valid_r;
  logic [15:0]        o_x_r, o_y_r;
  logic [2:0]         o_btn_r;
  logic [15:0]        o_scroll_r;
  logic               o_pend_r, o_done_r, o_drop_r;

  logic [15:0]        o_x_nxt, o_y_nxt, o_scroll_nxt;
  logic [2:0]         o_btn_nxt;
  logic               o_pend_nxt, o_done_nxt, o_drop_nxt;

  logic [15:0]        lim_x, lim_y;
  logic signed [9:0]  neg_dy;
  logic signed [16:0] scr_sum;

  function automatic logic [15:0] clip_pos(input logic [15:0] v);
    return ({1'b0, v} > ps2mt_pkg::POS_MAX) ? ps2mt_pkg::POS_MAX[15:0] : v;
  endfunction

  function automatic logic [15:0] axis_limit(input logic [15:0] size);
    logic [15:0] lim;
    lim = (size == 16'd0) ? 16'd0 : size - 16'd1;
    return clip_pos(lim);
  endfunction

  function automatic logic [15:0] move_axis(input logic [15:0]       pos,
                                            input logic signed [9:0] delta,
                                            input logic [15:0]       lim);
    logic signed [17:0] n;
    n = $signed({2'b00, pos}) + $signed({{8{delta[9]}}, delta});
    if (n[17]) begin
      return 16'd0;
    end else if (n[16:0] > {1'b0, lim}) begin
      return lim;
    end else begin
      return n[15:0];
    end
  endfunction

  assign q_pop  = !q_empty && (!out_valid_r || out_if.ready);
  assign lim_x  = axis_limit(screen_width);
  assign lim_y  = axis_limit(screen_height);
  assign neg_dy = -$signed({q_data.dy[8], q_data.dy});
  assign scr_sum = $signed({scroll_r[15], scroll_r}) +
                   $signed({{13{q_data.dz[3]}}, q_data.dz});

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    btn_nxt    = btn_r;
    scroll_nxt = scroll_r;
    pend_nxt   = pend_r;
    o_done_nxt = 1'b0;
    o_drop_nxt = 1'b0;
    case (q_data.kind)
      ps2mt_pkg::CMD_APPLY: begin
        cur_x_nxt = move_axis(cur_x_r, $signed({q_data.dx[8], q_data.dx}), lim_x);
        cur_y_nxt = move_axis(cur_y_r, neg_dy, lim_y);
        btn_nxt   = q_data.buttons;
        if (q_data.use_wheel) begin
          case (scr_sum[16:15])
            2'b01:   scroll_nxt = 16'h7FFF;
            2'b10:   scroll_nxt = 16'h8000;
            default: scroll_nxt = scr_sum[15:0];
          endcase
        end
        pend_nxt   = 1'b1;
        o_done_nxt = 1'b1;
      end
      ps2mt_pkg::CMD_DROP: o_drop_nxt = 1'b1;
      ps2mt_pkg::CMD_READ: begin
        scroll_nxt = 16'd0;
        pend_nxt   = 1'b0;
      end
      ps2mt_pkg::CMD_CENTER: begin
        cur_x_nxt = clip_pos({1'b0, screen_width[15:1]});
        cur_y_nxt = clip_pos({1'b0, screen_height[15:1]});
      end
      default: ;
    endcase
    // a read reports the state before clearing
    if (q_data.kind == ps2mt_pkg::CMD_READ) begin
      o_x_nxt      = cur_x_r;
      o_y_nxt      = cur_y_r;
      o_btn_nxt    = btn_r;
      o_scroll_nxt = scroll_r;
      o_pend_nxt   = pend_r;
    end else begin
      o_x_nxt      = cur_x_nxt;
      o_y_nxt      = cur_y_nxt;
      o_btn_nxt    = btn_nxt;
      o_scroll_nxt = scroll_nxt;
      o_pend_nxt   = pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= 16'd0;
      cur_y_r     <= 16'd0;
      btn_r       <= 3'd0;
      scroll_r    <= 16'd0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        btn_r       <= btn_nxt;
        scroll_r    <= scroll_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_x_r      <= o_x_nxt;
      o_y_r      <= o_y_nxt;
      o_btn_r    <= o_btn_nxt;
      o_scroll_r <= o_scroll_nxt;
      o_pend_r   <= o_pend_nxt;
      o_done_r   <= o_done_nxt;
      o_drop_r   <= o_drop_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.pos_x          = o_x_r;
  assign out_if.pos_y          = o_y_r;
  assign out_if.button_bits    = o_btn_r;
  assign out_if.scroll_sum     = $signed(o_scroll_r);
  assign out_if.update_pending = o_pend_r;
  assign out_if.packet_done    = o_done_r;
  assign out_if.packet_dropped = o_drop_r;

endmodule

`default_nettype wire

/* rtl/ps2_mouse_packet_tracker.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// PS/2 mouse byte framer and cursor / button / wheel state tracker.
// ----------------------------------------------------------------------------
// Requests arrive on in_if (valid/ready): opcode 0 carries a mouse byte in
// rx_byte, opcode 1 reads the state and clears pending and scroll, opcode 2
// recenters the cursor. Every request yields exactly one result on out_if.
// Screen width, height and wheel mode are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while the block is idle (not enforced).
// The front classifies a request combinationally and writes it into the
// command queue when it is accepted; the back end pops it into the output
// register once that register is free or its result is taken, and the
// result is offered on out_if from there.
// Throughput: one request per cycle while out_if keeps taking results.
// When out_if stalls, the two-entry command queue absorbs requests; in_if.ready
// drops once it is full and rises again as results drain.
// Reset (rst_n low, synchronous) clears framing, cursor, buttons, scroll,
// pending and the queue, and loads 1024 x 768 with wheel mode off.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ps2mt_in_if.sink         in_if,
  ps2mt_out_if.source      out_if,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]     width_r, height_r;
  logic            wheel_r;
  logic            q_push, q_pop, q_full, q_empty;
  ps2mt_pkg::cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ps2mt_pkg::WIDTH_RESET;
      height_r <= ps2mt_pkg::HEIGHT_RESET;
      wheel_r  <= 1'b0;
    end else if (cfg_we) begin
      case (ps2mt_pkg::cfg_index_t'(cfg_index))
        ps2mt_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        ps2mt_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        ps2mt_pkg::CFG_WHEEL_MODE:    wheel_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ps2mt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .wheel_mode (wheel_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  ps2mt_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ps2mt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (width_r),
    .screen_height (height_r),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .out_if        (out_if)
  );

endmodule

`default_nettype wire

/* rtl/ps2mt_checker.sv */
// ----------------------------------------------------------------------------
// ps2mt_checker
// Port-level checks on the tracker's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] pos_x,
  input wire logic        update_pending,
  input wire logic        packet_done,
  input wire logic        packet_dropped
);

  // a result held back by the receiver stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // nothing offered right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_done_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(packet_done && packet_dropped))
    else $error("packet both applied and dropped");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && packet_done |-> update_pending)
    else $error("applied packet without pending");

  // clamp keeps the cursor at most width minus one; this checks only x != 16'hFFFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pos_x != 16'hFFFF)
    else $error("cursor x out of range");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .pos_x          (out_if.pos_x),
  .update_pending (out_if.update_pending),
  .packet_done    (out_if.packet_done),
  .packet_dropped (out_if.packet_dropped)
);

`default_nettype wire

/* bench/ps2mt_tb_pkg.sv */
// ----------------------------------------------------------------------------
// ps2mt_tb_pkg
// Cursor/button/wheel state model and result checker for the PS/2 mouse
// packet tracker bench. Each accepted request is run through the model and
// the result it must produce is queued; results leaving the block are
// compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
package ps2mt_tb_pkg;

  import ps2mt_pkg::*;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [2:0]         buttons;
    logic signed [15:0] scroll;
    logic               pending;
    logic               done;
    logic               dropped;
  } mouse_view_t;

  class mouse_state_model;
    logic [15:0]        width;
    logic [15:0]        height;
    logic               wheel;

    logic [1:0]         byte_idx;
    logic [7:0]         pkt [3];
    logic [15:0]        cur_x;
    logic [15:0]        cur_y;
    logic [2:0]         held;
    logic signed [15:0] scroll;
    logic               pending;

    mouse_view_t        state_snapshots [$];

    int mismatches;
    int requests;
    int applied;
    int dropped_pkts;
    int reads;
    int sat_hits;

    function new();
      width    = WIDTH_RESET;
      height   = HEIGHT_RESET;
      wheel    = 1'b0;
      byte_idx = '0;
      foreach (pkt[i]) pkt[i] = '0;
      cur_x    = '0;
      cur_y    = '0;
      held     = '0;
      scroll   = '0;
      pending  = 1'b0;
      mismatches = 0;
      requests = 0;
      applied = 0;
      dropped_pkts = 0;
      reads = 0;
      sat_hits = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [15:0] v);
      case (idx)
        CFG_SCREEN_WIDTH:  width  = v;
        CFG_SCREEN_HEIGHT: height = v;
        CFG_WHEEL_MODE:    wheel  = v[0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return state_snapshots.size();
    endfunction

    function void push_view(logic done, logic drop);
      mouse_view_t v;
      v.pos_x   = cur_x;
      v.pos_y   = cur_y;
      v.buttons = held;
      v.scroll  = scroll;
      v.pending = pending;
      v.done    = done;
      v.dropped = drop;
      state_snapshots.push_back(v);
    endfunction

    function logic [15:0] clamp_axis(logic [15:0] pos, int delta, logic [15:0] size);
      int n;
      int lim;
      n   = int'(pos) + delta;
      lim = (size == 16'd0) ? 0 : int'(size) - 1;
      if (lim > int'(POS_MAX)) lim = int'(POS_MAX);
      if (n < 0) n = 0;
      if (n > lim) n = lim;
      return n[15:0];
    endfunction

    function void take_byte(logic [7:0] b);
      logic [1:0] last;
      logic [7:0] flags;
      int dx;
      int dy;
      int dz;
      int s;
      last = wheel ? 2'd3 : 2'd2;
      // hunting for a header: bytes without the sync bit are skipped
      if (byte_idx == 2'd0 && !b[HDR_SYNC_BIT]) begin
        push_view(1'b0, 1'b0);
        return;
      end
      if (byte_idx < 2'd3) pkt[byte_idx] = b;
      if (byte_idx < last && byte_idx < 2'd3) begin
        byte_idx = byte_idx + 2'd1;
        push_view(1'b0, 1'b0);
        return;
      end
      byte_idx = '0;
      flags = pkt[0];
      if ((flags & HDR_OVF_MASK) != 8'h00) begin
        dropped_pkts++;
        push_view(1'b0, 1'b1);
        return;
      end
      dx = int'(pkt[1]) - (flags[HDR_XSGN_BIT] ? 256 : 0);
      dy = int'(pkt[2]) - (flags[HDR_YSGN_BIT] ? 256 : 0);
      cur_x = clamp_axis(cur_x, dx, width);
      cur_y = clamp_axis(cur_y, -dy, height);
      held  = flags[2:0];
      if (wheel) begin
        dz = int'(b[3:0]);
        if (b[3]) dz -= 16;
        s = int'(scroll) + dz;
        if (s > 32767) begin
          s = 32767;
          sat_hits++;
        end
        if (s < -32768) begin
          s = -32768;
          sat_hits++;
        end
        scroll = s[15:0];
      end
      pending = 1'b1;
      applied++;
      push_view(1'b1, 1'b0);
    endfunction

    function void note_request(opcode_t op, logic [7:0] b);
      logic [16:0] cx;
      logic [16:0] cy;
      requests++;
      case (op)
        OP_BYTE: take_byte(b);
        OP_READ: begin
          reads++;
          push_view(1'b0, 1'b0);
          pending = 1'b0;
          scroll  = '0;
        end
        OP_CENTER: begin
          cx = {1'b0, width} >> 1;
          cy = {1'b0, height} >> 1;
          if (cx > POS_MAX) cx = POS_MAX;
          if (cy > POS_MAX) cy = POS_MAX;
          cur_x = cx[15:0];
          cur_y = cy[15:0];
          push_view(1'b0, 1'b0);
        end
        default: push_view(1'b0, 1'b0);
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      // cap the log; every mismatch is still counted
      if (mismatches < 40)
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(mouse_view_t got);
      mouse_view_t want;
      if (state_snapshots.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.pos_x), 32'h0);
        return;
      end
      want = state_snapshots.pop_front();
      if (got.pos_x !== want.pos_x)     report_mismatch("pos_x", 32'(got.pos_x), 32'(want.pos_x));
      if (got.pos_y !== want.pos_y)     report_mismatch("pos_y", 32'(got.pos_y), 32'(want.pos_y));
      if (got.buttons !== want.buttons)
        report_mismatch("button_bits", 32'(got.buttons), 32'(want.buttons));
      if (got.scroll !== want.scroll)
        report_mismatch("scroll_sum", 32'(got.scroll), 32'(want.scroll));
      if (got.pending !== want.pending)
        report_mismatch("update_pending", 32'(got.pending), 32'(want.pending));
      if (got.done !== want.done)
        report_mismatch("packet_done", 32'(got.done), 32'(want.done));
      if (got.dropped !== want.dropped)
        report_mismatch("packet_dropped", 32'(got.dropped), 32'(want.dropped));
    endtask
  endclass

endpackage

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ps2_mouse_packet_tracker: directed packets and
// corner cases, then random packet streams under several screen setups and
// handshake idle/stall mixes, a long output stall and a wheel run both ways.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ps2mt_pkg::*;
  import ps2mt_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_request;
  int hold_left;

  ps2mt_in_if  in_ch ();
  ps2mt_out_if out_ch ();

  mouse_state_model tracker = new();

  ps2_mouse_packet_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    mouse_view_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pos_x   = out_ch.pos_x;
      got.pos_y   = out_ch.pos_y;
      got.buttons = out_ch.button_bits;
      got.scroll  = out_ch.scroll_sum;
      got.pending = out_ch.update_pending;
      got.done    = out_ch.packet_done;
      got.dropped = out_ch.packet_dropped;
      tracker.check_result(got);
    end
  end

  task automatic send_request(opcode_t op, logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.opcode  <= 2'($urandom);
      in_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_request(op, b);
  endtask

  task automatic send_bytes(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    send_request(OP_BYTE, a);
    send_request(OP_BYTE, b);
    send_request(OP_BYTE, c);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  task automatic program_screen(logic [15:0] w, logic [15:0] h, logic wm);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_WHEEL_MODE, {15'd0, wm});
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
      3: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
    endcase
  endtask

  // mostly well-formed packets with random content; some noise, truncation,
  // overflow headers and commands mixed in
  task automatic random_stream(int n_items, logic wm);
    int start;
    int r;
    logic [7:0] hdr;
    start = tracker.requests;
    while (tracker.requests - start < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        hdr = 8'($urandom) | 8'h08;
        if ($urandom_range(99) < 85) hdr &= 8'h3F;
        send_request(OP_BYTE, hdr);
        if ($urandom_range(99) < 95) begin
          send_request(OP_BYTE, 8'($urandom));
          send_request(OP_BYTE, 8'($urandom));
          if (wm || $urandom_range(99) < 5) send_request(OP_BYTE, 8'($urandom));
        end
      end else if (r < 80) begin
        send_request(OP_READ, 8'($urandom));
      end else if (r < 86) begin
        send_request(OP_CENTER, 8'($urandom));
      end else if (r < 89) begin
        send_request(OP_NONE, 8'($urandom));
      end else begin
        send_request(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic align_framing();
    while (tracker.byte_idx != 2'd0) send_request(OP_BYTE, 8'h00);
  endtask

  // wheel packets all pushing one way
  task automatic scroll_push(int packets, logic upward);
    logic [3:0] dz;
    repeat (packets) begin
      dz = upward ? 4'($urandom_range(6, 7)) : 4'(16 - $urandom_range(7, 8));
      send_bytes((8'($urandom) & 8'h37) | 8'h08, 8'($urandom), 8'($urandom));
      send_request(OP_BYTE, {4'($urandom), dz});
    end
  endtask

  task automatic random_phase(logic [15:0] w, logic [15:0] h, logic wm, int mode,
                              int n_items, int hold);
    program_screen(w, h, wm);
    set_idling(mode);
    if (hold != 0) hold_request = hold;
    random_stream(n_items, wm);
    settle();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SCREEN_WIDTH;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    hold_request  = 0;
    hold_left     = 0;
    set_idling(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, framing skip, delta extremes, overflow, recenter
    send_request(OP_NONE, 8'hFF);
    send_request(OP_READ, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_bytes(8'h0F, 8'hFF, 8'h00);
    send_bytes(8'h38, 8'h00, 8'h00);
    send_bytes(8'hC8, 8'h12, 8'h34);
    send_bytes(8'h48, 8'h01, 8'h01);
    send_request(OP_CENTER, 8'h00);
    send_request(OP_READ, 8'hFF);
    settle();

    // zero width, full height, wheel extremes
    program_screen(16'd0, 16'hFFFF, 1'b1);
    send_bytes(8'h0A, 8'h10, 8'hF0);
    send_request(OP_BYTE, 8'h08);
    send_bytes(8'h0C, 8'h01, 8'h01);
    send_request(OP_BYTE, 8'hF7);
    send_request(OP_CENTER, 8'h00);
    send_request(OP_READ, 8'h00);
    // leave a wheel packet open, switch to three-byte mode, then finish it
    send_bytes(8'h08, 8'h00, 8'h00);
    settle();
    write_reg(CFG_WHEEL_MODE, 16'd0);
    cfg_we <= 1'b0;
    send_request(OP_BYTE, 8'h0F);
    settle();

    random_phase(16'hFFFF, 16'hFFFF, 1'b1, 0, 250, 0);
    random_phase(16'd1, 16'd1, 1'b0, 1, 250, 0);
    random_phase(16'd640, 16'd480, 1'b1, 2, 250, 400);
    random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 1'b0, 3, 250, 0);
    random_phase(16'($urandom_range(1, 2048)), 16'($urandom_range(1, 2048)),
                 1'b1, 1, 250, 0);
    random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 1'($urandom), 3, 250, 0);

    program_screen(16'd800, 16'd600, 1'b1);
    set_idling(0);
    align_framing();
    send_request(OP_READ, 8'h00);
    scroll_push(30, 1'b1);
    send_request(OP_READ, 8'h00);
    scroll_push(30, 1'b0);
    send_request(OP_READ, 8'h00);
    settle();
    repeat (10) @(posedge clk);

    if (tracker.outstanding() != 0)
      tracker.report_mismatch("results missing", 32'(tracker.outstanding()), 32'h0);
    $display("ran %0d requests: %0d packets applied, %0d dropped on overflow, %0d reads",
             tracker.requests, tracker.applied, tracker.dropped_pkts, tracker.reads);
    $display("scroll clipped %0d times; screens from 0 to 65535 wide, both packet sizes",
             tracker.sat_hits);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
